// ===== src/cps_pkg.sv =====
// shared types, codes and constants of the coulomb potential summation block
package cps_pkg;

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_AW = 3;
  localparam logic [CFG_AW-1:0] CFG_LOCAL_MODE    = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_ATOM_COUNT    = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_DECAY_RATE    = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_SCREEN_WEIGHT = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_OUTPUT_SCALE  = 3'd4;

  // configuration reset values
  localparam logic [10:0] ATOM_COUNT_RST    = 11'd0;
  localparam logic [15:0] DECAY_RATE_RST    = 16'd21571;
  localparam logic [15:0] SCREEN_WEIGHT_RST = 16'd10837;
  localparam logic [15:0] OUTPUT_SCALE_RST  = 16'd12089;

  // exp(-x) table in steps of 1/16
  localparam int unsigned EXP_STEPS = 256;
  localparam logic [63:0] EXP_RATIO = 64'd4034748382;

  // one stored atom
  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic signed [15:0] charge;
    logic        [15:0] radius;
  } atom_t;

  typedef logic [16:0] exp_tab_t [EXP_STEPS];

  // operations of the shared iterative unit
  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_e;

  // arithmetic steps of one atom and of the final scaling
  typedef enum logic [3:0] {
    STEP_SQX,
    STEP_SQY,
    STEP_SQZ,
    STEP_SQRT,
    STEP_DIV,
    STEP_RK,
    STEP_A2,
    STEP_A4,
    STEP_A2D6,
    STEP_A4D120,
    STEP_KD,
    STEP_WS,
    STEP_XE,
    STEP_TF,
    STEP_OSC
  } step_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LATCH,
    ST_ISSUE,
    ST_WAIT,
    ST_ACCUM,
    ST_OUTPUT
  } ctrl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic  load;
    logic  q_init;
    logic  rd_en;
    logic  latch;
    logic  unit_start;
    logic  wb;
    logic  accum;
    step_e step;
  } cps_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic all_done;
    logic unit_done;
    logic unit_zero;
    logic local_mode;
  } cps_sts_t;

  // builds the exp(-k/16) table in Q1.32 then rounds to Q1.16
  function automatic exp_tab_t exp_table_f();
    exp_tab_t    tab;
    logic [63:0] t;
    t = 64'd1 << 32;
    for (int i = 0; i < EXP_STEPS; i++) begin
      tab[i] = 17'((t + 64'd32768) >> 16);
      t = (t * EXP_RATIO + 64'h8000_0000) >> 32;
    end
    return tab;
  endfunction

endpackage

// ===== src/coulomb_potential_sum.sv =====
// top level of the coulomb potential summation block
// A load item (req_type 0) writes one atom into the store in the cycle it is
// taken and leaves busy low. A query (req_type 1) walks atoms 0 .. atom_count-1
// through one shared serial unit (shift-add multiply, 48-step restoring divide,
// 25-step square root); the steps of each atom run one after another on it. An
// atom costs more in nonlocal mode than in local mode and less for short
// operands, an atom at zero distance stops after the root, and a final scaling
// follows the last atom. busy stays high for the
// whole query, and the result appears on potential_o and saturated_o with
// valid_o high for exactly one cycle; the receiver must take it then.
module coulomb_potential_sum #(
  parameter int unsigned MAX_ATOMS = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       req_type_i,
  input  logic [9:0]                 atom_slot_i,
  input  logic signed [23:0]         coord_x_i,
  input  logic signed [23:0]         coord_y_i,
  input  logic signed [23:0]         coord_z_i,
  input  logic signed [15:0]         atom_charge_i,
  input  logic [15:0]                atom_radius_i,
  input  logic                       cfg_we_i,
  input  logic [cps_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [15:0]                cfg_wdata_i,
  output logic                       valid_o,
  output logic signed [39:0]         potential_o,
  output logic                       saturated_o
);

  cps_pkg::cps_cmd_t cmd;
  cps_pkg::cps_sts_t sts;

  // sequencer
  cps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .busy       (busy),
    .valid_o    (valid_o),
    .cmd_o      (cmd)
  );

  // store and arithmetic
  cps_datapath #(
    .MAX_ATOMS (MAX_ATOMS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .atom_slot_i   (atom_slot_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .atom_charge_i (atom_charge_i),
    .atom_radius_i (atom_radius_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .potential_o   (potential_o),
    .saturated_o   (saturated_o)
  );

endmodule

// ===== src/cps_alu.sv =====
// shared iterative unit: shift-add multiply, restoring divide, integer square root
module cps_alu (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  cps_pkg::alu_op_e      op_i,
  input  logic [63:0]           opa_i,
  input  logic [63:0]           opb_i,
  output logic                  done_o,
  output logic [63:0]           res_o
);

  localparam int unsigned DivBits = 48;
  localparam logic [63:0] SqrtTop = 64'd1 << 48;

  logic             busy_q, done_q;
  cps_pkg::alu_op_e op_q;
  logic [63:0]      a_q, b_q, res_q, rem_q;
  logic [5:0]       cnt_q;

  logic [63:0] rem_sh, sq_t;
  logic        div_ge, sq_ge;

  // one divide or root step
  always_comb begin
    rem_sh = {rem_q[62:0], a_q[DivBits-1]};
    div_ge = rem_sh >= b_q;
    sq_t   = res_q + b_q;
    sq_ge  = rem_q >= sq_t;
  end

  // busy and done control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q) begin
        case (op_q)
          cps_pkg::ALU_MUL: begin
            if (b_q == 64'd0) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
          cps_pkg::ALU_DIV: begin
            if (cnt_q == 6'd1) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
          cps_pkg::ALU_SQRT: begin
            if (b_q == 64'd1) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
          default: busy_q <= 1'b0;
        endcase
      end
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q  <= op_i;
      a_q   <= opa_i;
      res_q <= 64'd0;
      cnt_q <= 6'(DivBits);
      if (op_i == cps_pkg::ALU_SQRT) begin
        rem_q <= opa_i;
        b_q   <= SqrtTop;
      end else begin
        rem_q <= 64'd0;
        b_q   <= opb_i;
      end
    end else if (busy_q) begin
      case (op_q)
        cps_pkg::ALU_MUL: begin
          if (b_q[0]) begin
            res_q <= res_q + a_q;
          end
          a_q <= a_q << 1;
          b_q <= b_q >> 1;
        end
        cps_pkg::ALU_DIV: begin
          a_q   <= a_q << 1;
          rem_q <= div_ge ? rem_sh - b_q : rem_sh;
          res_q <= {res_q[62:0], div_ge};
          cnt_q <= cnt_q - 6'd1;
        end
        cps_pkg::ALU_SQRT: begin
          if (sq_ge) begin
            rem_q <= rem_q - sq_t;
            res_q <= (res_q >> 1) + b_q;
          end else begin
            res_q <= res_q >> 1;
          end
          b_q <= b_q >> 2;
        end
        default: res_q <= res_q;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // a new operation never lands on one in flight
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("unit started while busy");

  // done is a single pulse at the end of an operation
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("unit done held");

endmodule

// ===== src/cps_datapath.sv =====
// datapath: atom store, configuration registers, per-atom arithmetic and accumulator
module cps_datapath #(
  parameter int unsigned MAX_ATOMS = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cps_pkg::cps_cmd_t          cmd_i,
  output cps_pkg::cps_sts_t          sts_o,
  input  logic [9:0]                 atom_slot_i,
  input  logic signed [23:0]         coord_x_i,
  input  logic signed [23:0]         coord_y_i,
  input  logic signed [23:0]         coord_z_i,
  input  logic signed [15:0]         atom_charge_i,
  input  logic [15:0]                atom_radius_i,
  input  logic                       cfg_we_i,
  input  logic [cps_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [15:0]                cfg_wdata_i,
  output logic signed [39:0]         potential_o,
  output logic                       saturated_o
);

  localparam int unsigned AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ATOMS + 1);
  localparam int unsigned SW = (AW > 10) ? AW : 10;
  localparam int unsigned NW = (CW > 11) ? CW : 11;

  localparam cps_pkg::exp_tab_t ExpTab = cps_pkg::exp_table_f();

  localparam logic [35:0] FactMax    = 36'hF_FFFF_FFFF;
  localparam logic [47:0] OutPosMax  = 48'd549755813887;
  localparam logic [47:0] OutNegMax  = 48'd549755813888;
  localparam logic signed [49:0] AccMax = 50'sd140737488355327;
  localparam logic signed [49:0] AccMin = -50'sd140737488355328;
  // ceil(2^33/3), exact for a 31-bit dividend
  localparam logic [63:0] RecipThree   = 64'd2863311531;
  // ceil(2^29/15), exact for a 25-bit dividend
  localparam logic [63:0] RecipFifteen = 64'd35791395;
  // (2^24-1)/15
  localparam logic [21:0] RepFifteen   = 22'h111111;

  // configuration registers
  logic        local_q;
  logic [10:0] count_q;
  logic [15:0] decay_q, weight_q, scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_q  <= 1'b1;
      count_q  <= cps_pkg::ATOM_COUNT_RST;
      decay_q  <= cps_pkg::DECAY_RATE_RST;
      weight_q <= cps_pkg::SCREEN_WEIGHT_RST;
      scale_q  <= cps_pkg::OUTPUT_SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        cps_pkg::CFG_LOCAL_MODE:    local_q  <= cfg_wdata_i[0];
        cps_pkg::CFG_ATOM_COUNT:    count_q  <= cfg_wdata_i[10:0];
        cps_pkg::CFG_DECAY_RATE:    decay_q  <= cfg_wdata_i;
        cps_pkg::CFG_SCREEN_WEIGHT: weight_q <= cfg_wdata_i;
        cps_pkg::CFG_OUTPUT_SCALE:  scale_q  <= cfg_wdata_i;
        default:                    local_q  <= local_q;
      endcase
    end
  end

  // atom store
  cps_pkg::atom_t store_mem [MAX_ATOMS];
  cps_pkg::atom_t rdata_q, wdata;
  logic [SW-1:0]  slot_ext;
  logic           slot_ok;
  logic [CW-1:0]  idx_q, n_q;

  always_comb begin
    slot_ext = SW'(atom_slot_i);
    slot_ok  = (SW+1)'(slot_ext) < (SW+1)'(MAX_ATOMS);
    wdata    = '{x: coord_x_i, y: coord_y_i, z: coord_z_i,
                 charge: atom_charge_i, radius: atom_radius_i};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && slot_ok) begin
      store_mem[slot_ext[AW-1:0]] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= store_mem[idx_q[AW-1:0]];
    end
  end

  // query state and per-atom intermediates
  logic signed [23:0] qx_q, qy_q, qz_q;
  logic [24:0]  dxm_q, dym_q, dzm_q;
  logic [49:0]  dsq_q;
  logic [24:0]  d_q;
  logic         dzero_q;
  logic [47:0]  tm_q;
  logic [23:0]  a_q;
  logic [31:0]  a2_q;
  logic [47:0]  a4_q;
  logic [41:0]  s_q;
  logic [16:0]  e_q;
  logic [39:0]  x_q;
  logic [35:0]  f_q;
  logic signed [47:0] acc_q;
  logic         flag_q;
  logic signed [39:0] pot_q;
  logic         sat_q;

  // count limited to the store depth
  logic [NW-1:0] cnt_ext, cnt_lim;
  always_comb begin
    cnt_ext = NW'(count_q);
    cnt_lim = (cnt_ext > NW'(MAX_ATOMS)) ? NW'(MAX_ATOMS) : cnt_ext;
  end

  // coordinate differences as magnitudes
  logic signed [24:0] dx, dy, dz;
  logic [15:0]        cmag;
  logic [47:0]        accmag;
  logic [31:0]        s_clip;
  always_comb begin
    dx     = 25'(qx_q) - 25'(rdata_q.x);
    dy     = 25'(qy_q) - 25'(rdata_q.y);
    dz     = 25'(qz_q) - 25'(rdata_q.z);
    cmag   = rdata_q.charge[15] ? 16'(-rdata_q.charge) : 16'(rdata_q.charge);
    accmag = acc_q[47] ? 48'(-acc_q) : 48'(acc_q);
    s_clip = (s_q > 42'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s_q[31:0]
;
  end

  // a4/120 = (a4/8)/15; a4/8 = h*2^24 + l and 2^24 leaves 1 mod 15,
  // so the quotient is h*(2^24-1)/15 plus (h+l)/15
  logic [44:0] a4_eighth;
  logic [24:0] a4_fold;
  logic [41:0] a4_hi_quot;
  always_comb begin
    a4_eighth  = a4_q[47:3];
    a4_fold    = 25'(a4_eighth[44:24]) + 25'(a4_eighth[23:0]);
    a4_hi_quot = 42'(a4_eighth[44:24]) * 42'(RepFifteen);
  end

  // operand selection for the shared unit
  cps_pkg::alu_op_e alu_op;
  logic [63:0]      alu_a, alu_b, alu_res;
  logic             alu_done;

  always_comb begin
    alu_op = cps_pkg::ALU_MUL;
    alu_a  = 64'd0;
    alu_b  = 64'd0;
    case (cmd_i.step)
      cps_pkg::STEP_SQX: begin alu_a = 64'(dxm_q); alu_b = 64'(dxm_q); end
      cps_pkg::STEP_SQY: begin alu_a = 64'(dym_q); alu_b = 64'(dym_q); end
      cps_pkg::STEP_SQZ: begin alu_a = 64'(dzm_q); alu_b = 64'(dzm_q); end
      cps_pkg::STEP_SQRT: begin
        alu_op = cps_pkg::ALU_SQRT;
        alu_a  = 64'(dsq_q);
      end
      cps_pkg::STEP_DIV: begin
        alu_op = cps_pkg::ALU_DIV;
        alu_a  = 64'({cmag, 12'd0});
        alu_b  = 64'(d_q);
      end
      cps_pkg::STEP_RK: begin alu_a = 64'(rdata_q.radius); alu_b = 64'(decay_q); end
      cps_pkg::STEP_A2: begin alu_a = 64'(a_q); alu_b = 64'(a_q); end
      cps_pkg::STEP_A4: begin alu_a = 64'(a2_q); alu_b = 64'(a2_q); end
      // a2/6 as (a2/2)/3 by reciprocal multiply
      cps_pkg::STEP_A2D6: begin
        alu_a = 64'(a2_q[31:1]);
        alu_b = RecipThree;
      end
      // (h+l)/15 by reciprocal multiply
      cps_pkg::STEP_A4D120: begin
        alu_a = 64'(a4_fold);
        alu_b = RecipFifteen;
      end
      cps_pkg::STEP_KD:  begin alu_a = 64'(d_q); alu_b = 64'(decay_q); end
      cps_pkg::STEP_WS:  begin alu_a = 64'(s_clip); alu_b = 64'(weight_q); end
      cps_pkg::STEP_XE:  begin alu_a = 64'(x_q); alu_b = 64'(e_q); end
      cps_pkg::STEP_TF:  begin alu_a = 64'(f_q); alu_b = 64'(tm_q); end
      cps_pkg::STEP_OSC: begin alu_a = 64'(accmag); alu_b = 64'(scale_q); end
      default: alu_op = cps_pkg::ALU_MUL;
    endcase
  end

  cps_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.unit_start),
    .op_i    (alu_op),
    .opa_i   (alu_a),
    .opb_i   (alu_b),
    .done_o  (alu_done),
    .res_o   (alu_res)
  );

  // nonlocal factor sum, output magnitude, accumulator sum
  logic [40:0]        f_sum;
  logic [47:0]        out_mag;
  logic signed [49:0] term, acc_sum;
  always_comb begin
    f_sum   = 41'(alu_res[56:16]) + 41'd65536;
    out_mag = alu_res[63:16];
    if (dzero_q) begin
      if (rdata_q.charge == 16'sd0) begin
        term = 50'sd0;
      end else if (rdata_q.charge[15]) begin
        term = -AccMax;
      end else begin
        term = AccMax;
      end
    end else begin
      term = rdata_q.charge[15] ? -$signed({2'b00, tm_q}) : $signed({2'b00, tm_q});
    end
    acc_sum = 50'(acc_q) + term;
  end

  // per-step register updates
  always_ff @(posedge clk_i) begin
    if (cmd_i.q_init) begin
      qx_q   <= coord_x_i;
      qy_q   <= coord_y_i;
      qz_q   <= coord_z_i;
      n_q    <= CW'(cnt_lim);
      idx_q  <= '0;
      acc_q  <= '0;
      flag_q <= 1'b0;
    end
    if (cmd_i.latch) begin
      dxm_q <= dx[24] ? 25'(-dx) : 25'(dx);
      dym_q <= dy[24] ? 25'(-dy) : 25'(dy);
      dzm_q <= dz[24] ? 25'(-dz) : 25'(dz);
    end
    if (cmd_i.accum) begin
      idx_q <= idx_q + CW'(1);
      if (dzero_q) begin
        flag_q <= 1'b1;
      end
      if (acc_sum > AccMax) begin
        acc_q  <= 48'(AccMax);
        flag_q <= 1'b1;
      end else if (acc_sum < AccMin) begin
        acc_q  <= 48'(AccMin);
        flag_q <= 1'b1;
      end else begin
        acc_q <= 48'(acc_sum);
      end
    end
    if (cmd_i.wb) begin
      case (cmd_i.step)
        cps_pkg::STEP_SQX:    dsq_q <= alu_res[49:0];
        cps_pkg::STEP_SQY:    dsq_q <= dsq_q + alu_res[49:0];
        cps_pkg::STEP_SQZ:    dsq_q <= dsq_q + alu_res[49:0];
        cps_pkg::STEP_SQRT: begin
          d_q     <= alu_res[24:0];
          dzero_q <= (alu_res == 64'd0);
        end
        cps_pkg::STEP_DIV:    tm_q <= alu_res[47:0];
        cps_pkg::STEP_RK:     a_q  <= alu_res[31:8];
        cps_pkg::STEP_A2:     a2_q <= alu_res[47:16];
        cps_pkg::STEP_A4:     a4_q <= alu_res[63:16];
        cps_pkg::STEP_A2D6:   s_q  <= 42'd65536 + 42'(alu_res[62:33]);
        cps_pkg::STEP_A4D120: s_q  <= s_q + a4_hi_quot + 42'(alu_res[50:29]);
        cps_pkg::STEP_KD: begin
          if (alu_res[40:28] == 13'd0) begin
            e_q <= ExpTab[alu_res[27:20]];
          end else begin
            e_q <= 17'd0;
          end
        end
        cps_pkg::STEP_WS:     x_q <= alu_res[47:8];
        cps_pkg::STEP_XE: begin
          if (f_sum > 41'(FactMax)) begin
            f_q    <= FactMax;
            flag_q <= 1'b1;
          end else begin
            f_q <= f_sum[35:0];
          end
        end
        cps_pkg::STEP_TF:     tm_q <= alu_res[63:16];
        cps_pkg::STEP_OSC: begin
          if (acc_q[47]) begin
            pot_q <= (out_mag > OutNegMax) ? -40'sd549755813888 : 40'(-out_mag);
            sat_q <= flag_q | (out_mag > OutNegMax);
          end else begin
            pot_q <= (out_mag > OutPosMax) ? 40'sd549755813887 : 40'(out_mag);
            sat_q <= flag_q | (out_mag > OutPosMax);
          end
        end
        default: dsq_q <= dsq_q;
      endcase
    end
  end

  assign sts_o = '{all_done: (idx_q == n_q), unit_done: alu_done,
                   unit_zero: (alu_res == 64'd0), local_mode: local_q};

  assign potential_o = pot_q;
  assign saturated_o = sat_q;

  // the store is never read past the atoms of the query
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> (idx_q != n_q)) else $error("store read past atom count");

endmodule

// ===== src/cps_ctrl.sv =====
// controller: sequences loads, the per-atom steps of a query and the result strobe
module cps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              req_type_i,
  input  cps_pkg::cps_sts_t sts_i,
  output logic              busy,
  output logic              valid_o,
  output cps_pkg::cps_cmd_t cmd_o
);

  cps_pkg::ctrl_state_e state_q, state_d;
  cps_pkg::step_e       step_q, step_d;
  logic                 accept;

  // state and step registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cps_pkg::ST_IDLE;
      step_q  <= cps_pkg::STEP_SQX;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.step = step_q;
    busy    = (state_q != cps_pkg::ST_IDLE);
    valid_o = 1'b0;
    accept  = start && !busy;
    case (state_q)
      cps_pkg::ST_IDLE: begin
        cmd_o.load   = accept && (req_type_i == cps_pkg::REQ_LOAD);
        cmd_o.q_init = accept && (req_type_i == cps_pkg::REQ_QUERY);
        if (cmd_o.q_init) begin
          state_d = cps_pkg::ST_CHECK;
        end
      end
      cps_pkg::ST_CHECK: begin
        if (sts_i.all_done) begin
          step_d  = cps_pkg::STEP_OSC;
          state_d = cps_pkg::ST_ISSUE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = cps_pkg::ST_LATCH;
        end
      end
      cps_pkg::ST_LATCH: begin
        cmd_o.latch = 1'b1;
        step_d      = cps_pkg::STEP_SQX;
        state_d     = cps_pkg::ST_ISSUE;
      end
      cps_pkg::ST_ISSUE: begin
        cmd_o.unit_start = 1'b1;
        state_d          = cps_pkg::ST_WAIT;
      end
      cps_pkg::ST_WAIT: begin
        if (sts_i.unit_done) begin
          cmd_o.wb = 1'b1;
          state_d  = cps_pkg::ST_ISSUE;
          case (step_q)
            cps_pkg::STEP_SQX: step_d = cps_pkg::STEP_SQY;
            cps_pkg::STEP_SQY: step_d = cps_pkg::STEP_SQZ;
            cps_pkg::STEP_SQZ: step_d = cps_pkg::STEP_SQRT;
            cps_pkg::STEP_SQRT: begin
              if (sts_i.unit_zero) begin
                state_d = cps_pkg::ST_ACCUM;
              end else begin
                step_d = cps_pkg::STEP_DIV;
              end
            end
            cps_pkg::STEP_DIV: begin
              if (sts_i.local_mode) begin
                state_d = cps_pkg::ST_ACCUM;
              end else begin
                step_d = cps_pkg::STEP_RK;
              end
            end
            cps_pkg::STEP_RK:     step_d = cps_pkg::STEP_A2;
            cps_pkg::STEP_A2:     step_d = cps_pkg::STEP_A4;
            cps_pkg::STEP_A4:     step_d = cps_pkg::STEP_A2D6;
            cps_pkg::STEP_A2D6:   step_d = cps_pkg::STEP_A4D120;
            cps_pkg::STEP_A4D120: step_d = cps_pkg::STEP_KD;
            cps_pkg::STEP_KD:     step_d = cps_pkg::STEP_WS;
            cps_pkg::STEP_WS:     step_d = cps_pkg::STEP_XE;
            cps_pkg::STEP_XE:     step_d = cps_pkg::STEP_TF;
            cps_pkg::STEP_TF:     state_d = cps_pkg::ST_ACCUM;
            cps_pkg::STEP_OSC:    state_d = cps_pkg::ST_OUTPUT;
            default:              state_d = cps_pkg::ST_IDLE;
          endcase
        end
      end
      cps_pkg::ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = cps_pkg::ST_CHECK;
      end
      cps_pkg::ST_OUTPUT: begin
        valid_o = 1'b1;
        state_d = cps_pkg::ST_IDLE;
      end
      default: state_d = cps_pkg::ST_IDLE;
    endcase
  end

  // one result strobe per transfer
  a_valid_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe longer than one cycle");

  // the final scaling is always followed by the result
  a_osc_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cps_pkg::ST_WAIT && sts_i.unit_done && step_q == cps_pkg::STEP_OSC)
    |=> valid_o) else $error("scaled result not delivered");

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench of the coulomb potential summation block
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned STORE_DEPTH  = 1024;
  localparam int unsigned STALL_LIMIT  = 1500000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam longint      ACC_HI       = 64'sd140737488355327;
  localparam longint      ACC_LO       = -64'sd140737488355328;
  localparam longint      POT_HI       = 64'sd549755813887;
  localparam longint      POT_LO       = -64'sd549755813888;
  localparam logic [63:0] FACTOR_CAP   = 64'd68719476735;

  typedef struct {
    logic               req;
    logic [9:0]         slot;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic signed [15:0] charge;
    logic [15:0]        radius;
  } item_t;

  typedef struct {
    logic signed [39:0] potential;
    logic               saturated;
  } potential_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic                       req_type_i;
  logic [9:0]                 atom_slot_i;
  logic signed [23:0]         coord_x_i;
  logic signed [23:0]         coord_y_i;
  logic signed [23:0]         coord_z_i;
  logic signed [15:0]         atom_charge_i;
  logic [15:0]                atom_radius_i;
  logic                       cfg_we_i;
  logic [cps_pkg::CFG_AW-1:0] cfg_addr_i;
  logic [15:0]                cfg_wdata_i;
  logic                       valid_o;
  logic signed [39:0]         potential_o;
  logic                       saturated_o;

  // pending items, expected potentials, error count
  item_t       pending_items[$];
  potential_t  potential_q[$];
  int unsigned error_cnt;
  int unsigned cycle_cnt;
  int unsigned stall_cnt;
  item_t       cur_item;

  // shadow of the block: atom store, registers, exp table
  cps_pkg::atom_t atom_mem[STORE_DEPTH];
  logic [31:0]    exp_lut[cps_pkg::EXP_STEPS];
  logic           sh_local;
  logic [10:0]    sh_count;
  logic [15:0]    sh_decay;
  logic [15:0]    sh_weight;
  logic [15:0]    sh_scale;

  // positions as planned, used to aim queries at atoms
  logic signed [23:0] plan_x[STORE_DEPTH];
  logic signed [23:0] plan_y[STORE_DEPTH];
  logic signed [23:0] plan_z[STORE_DEPTH];

  coulomb_potential_sum u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .atom_slot_i  (atom_slot_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .coord_z_i    (coord_z_i),
    .atom_charge_i(atom_charge_i),
    .atom_radius_i(atom_radius_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .valid_o      (valid_o),
    .potential_o  (potential_o),
    .saturated_o  (saturated_o)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // floor of the square root, bit by bit
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // screening factor 1 + w*sinh(a)/a*exp(-k*d), Q.16
  function automatic logic [63:0] screen_factor(input logic [63:0] d, input logic [15:0] rad,
                                                output logic clamp);
    logic [63:0] k, a, a2, a4, s, e, idx, f;
    k = 64'(sh_decay);
    a = (64'(rad) * k) >> 8;
    a2 = (a * a) >> 16;
    a4 = (a2 * a2) >> 16;
    s = 64'd65536 + a2 / 64'd6 + a4 / 64'd120;
    if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
    idx = (k * d) >> 20;
    e = (idx < cps_pkg::EXP_STEPS) ? 64'(exp_lut[idx]) : 64'd0;
    f = 64'd65536 + ((((64'(sh_weight) * s) >> 8) * e) >> 16);
    clamp = 1'b0;
    if (f > FACTOR_CAP) begin
      clamp = 1'b1;
      f = FACTOR_CAP;
    end
    return f;
  endfunction

  // potential at a query point over the stored atoms
  function automatic potential_t query_potential(input item_t it);
    potential_t  res;
    longint      acc, term, dx, dy, dz, sres;
    logic [63:0] dsq, d, cm, tm, mag, f;
    logic        flag, clamp, neg;
    int          n;
    acc = 0;
    flag = 1'b0;
    n = (sh_count > STORE_DEPTH) ? STORE_DEPTH : int'(sh_count);
    for (int i = 0; i < n; i++) begin
      dx = longint'(it.x) - longint'(atom_mem[i].x);
      dy = longint'(it.y) - longint'(atom_mem[i].y);
      dz = longint'(it.z) - longint'(atom_mem[i].z);
      dsq = 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
      d = floor_sqrt(dsq);
      neg = atom_mem[i].charge < 0;
      if (d == 0) begin
        flag = 1'b1;
        term = (atom_mem[i].charge > 0) ? ACC_HI : (neg ? -ACC_HI : 0);
      end else begin
        cm = 64'(neg ? -longint'(atom_mem[i].charge) : longint'(atom_mem[i].charge)) << 12;
        tm = cm / d;
        if (!sh_local) begin
          f = screen_factor(d, atom_mem[i].radius, clamp);
          if (clamp) flag = 1'b1;
          tm = (tm * f) >> 16;
        end
        term = neg ? -longint'(tm) : longint'(tm);
      end
      acc = acc + term;
      if (acc > ACC_HI) begin
        acc = ACC_HI;
        flag = 1'b1;
      end
      if (acc < ACC_LO) begin
        acc = ACC_LO;
        flag = 1'b1;
      end
    end
    mag = 64'(acc < 0 ? -acc : acc);
    mag = (mag * 64'(sh_scale)) >> 16;
    sres = (acc < 0) ? -longint'(mag) : longint'(mag);
    if (sres > POT_HI) begin
      sres = POT_HI;
      flag = 1'b1;
    end
    if (sres < POT_LO) begin
      sres = POT_LO;
      flag = 1'b1;
    end
    res.potential = 40'(sres);
    res.saturated = flag;
    return res;
  endfunction

  // driver: feeds pending items, updates the shadow on each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start         <= 1'b0;
      req_type_i    <= cps_pkg::REQ_LOAD;
      atom_slot_i   <= '0;
      coord_x_i     <= '0;
      coord_y_i     <= '0;
      coord_z_i     <= '0;
      atom_charge_i <= '0;
      atom_radius_i <= '0;
      cycle_cnt     <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (start && !busy) begin
        if (cur_item.req == cps_pkg::REQ_LOAD) begin
          atom_mem[cur_item.slot] = '{x: cur_item.x, y: cur_item.y, z: cur_item.z,
                                      charge: cur_item.charge, radius: cur_item.radius};
        end else begin
          potential_q.push_back(query_potential(cur_item));
        end
      end
      if (start && busy) begin
        // hold the item until it is taken
      end else if (pending_items.size() > 0 &&
                   !((cycle_cnt % 3000 > 900) && ($urandom_range(0, 99) < 10))) begin
        cur_item = pending_items.pop_front();
        start         <= 1'b1;
        req_type_i    <= cur_item.req;
        atom_slot_i   <= cur_item.slot;
        coord_x_i     <= cur_item.x;
        coord_y_i     <= cur_item.y;
        coord_z_i     <= cur_item.z;
        atom_charge_i <= cur_item.charge;
        atom_radius_i <= cur_item.radius;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compares each result with the oldest expectation, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) begin
        if (potential_q.size() == 0) begin
          $error("unexpected result potential %0d saturated %0b", potential_o, saturated_o);
          error_cnt++;
        end else begin
          potential_t want;
          want = potential_q.pop_front();
          if (potential_o !== want.potential) begin
            $error("potential: expected %0d actual %0d", want.potential, potential_o);
            error_cnt++;
          end
          if (saturated_o !== want.saturated) begin
            $error("saturated: expected %0b actual %0b", want.saturated, saturated_o);
            error_cnt++;
          end
        end
      end
      if ((start && !busy) || valid_o) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // register write, shadow updated alongside
  task automatic cfg_write(input logic [cps_pkg::CFG_AW-1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx)
      cps_pkg::CFG_LOCAL_MODE:    sh_local  = val[0];
      cps_pkg::CFG_ATOM_COUNT:    sh_count  = val[10:0];
      cps_pkg::CFG_DECAY_RATE:    sh_decay  = val;
      cps_pkg::CFG_SCREEN_WEIGHT: sh_weight = val;
      cps_pkg::CFG_OUTPUT_SCALE:  sh_scale  = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every item is taken and every potential has come back
  task automatic wait_drained();
    while (pending_items.size() != 0 || start || potential_q.size() != 0 || busy)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic lm, input logic [10:0] cnt, input logic [15:0] k,
                            input logic [15:0] w, input logic [15:0] sc);
    wait_drained();
    cfg_write(cps_pkg::CFG_LOCAL_MODE, 16'(lm));
    cfg_write(cps_pkg::CFG_ATOM_COUNT, 16'(cnt));
    cfg_write(cps_pkg::CFG_DECAY_RATE, k);
    cfg_write(cps_pkg::CFG_SCREEN_WEIGHT, w);
    cfg_write(cps_pkg::CFG_OUTPUT_SCALE, sc);
  endtask

  task automatic push_load(input logic [9:0] slot, input logic signed [23:0] x,
                           input logic signed [23:0] y, input logic signed [23:0] z,
                           input logic signed [15:0] q, input logic [15:0] r);
    item_t it;
    it = '{req: cps_pkg::REQ_LOAD, slot: slot, x: x, y: y, z: z, charge: q, radius: r};
    plan_x[slot] = x;
    plan_y[slot] = y;
    plan_z[slot] = z;
    pending_items.push_back(it);
  endtask

  // a query carries random junk in the fields it does not use
  task automatic push_query(input logic signed [23:0] x, input logic signed [23:0] y,
                            input logic signed [23:0] z);
    item_t it;
    it = '{req: cps_pkg::REQ_QUERY, slot: 10'($urandom), x: x, y: y, z: z,
           charge: 16'($urandom), radius: 16'($urandom)};
    pending_items.push_back(it);
  endtask

  function automatic logic signed [23:0] rand_coord();
    if ($urandom_range(0, 99) < 80) return 24'($signed($urandom_range(0, 8191)) - 4096);
    return 24'($urandom);
  endfunction

  function automatic logic [15:0] rand_reg();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic rand_load(input logic [9:0] slot);
    push_load(slot, rand_coord(), rand_coord(), rand_coord(), 16'($urandom),
              ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 1024)));
  endtask

  // random phase: fill the counted slots, then mixed loads and queries
  task automatic rand_phase(input int n_items, input int cnt);
    int s;
    set_config(1'($urandom_range(0, 1)), 11'(cnt), rand_reg(), rand_reg(), rand_reg());
    if ($urandom_range(0, 3) == 0)
      cfg_write(cps_pkg::CFG_OUTPUT_SCALE + 3'($urandom_range(1, 3)), 16'($urandom));
    for (int i = 0; i < cnt; i++) rand_load(10'(i));
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 30) begin
        rand_load(10'($urandom_range(0, STORE_DEPTH - 1)));
      end else if (cnt > 0 && $urandom_range(0, 99) < 15) begin
        s = $urandom_range(0, cnt - 1);
        push_query(plan_x[s], plan_y[s], plan_z[s]);
      end else begin
        push_query(rand_coord(), rand_coord(), rand_coord());
      end
    end
  endtask

  // stimulus
  initial begin
    logic [63:0] t;
    t = 64'd1 << 32;
    for (int i = 0; i < cps_pkg::EXP_STEPS; i++) begin
      exp_lut[i] = 32'((t + 64'd32768) >> 16);
      t = (t * cps_pkg::EXP_RATIO + 64'h8000_0000) >> 32;
    end
    sh_local    = 1'b1;
    sh_count    = cps_pkg::ATOM_COUNT_RST;
    sh_decay    = cps_pkg::DECAY_RATE_RST;
    sh_weight   = cps_pkg::SCREEN_WEIGHT_RST;
    sh_scale    = cps_pkg::OUTPUT_SCALE_RST;
    error_cnt   = 0;
    stall_cnt   = 0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = '0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: no atoms counted
    push_query(24'sd0, 24'sd0, 24'sd0);

    // local mode: zero distance, distant atoms, coordinate extremes
    set_config(1'b1, 11'd3, cps_pkg::DECAY_RATE_RST, cps_pkg::SCREEN_WEIGHT_RST, 16'hFFFF);
    push_load(10'd0, 24'sd0, 24'sd0, 24'sd0, 16'sh7FFF, 16'd0);
    push_load(10'd1, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 16'sh8000, 16'hFFFF);
    push_load(10'd2, 24'sd256, -24'sd256, 24'sd512, 16'sd0, 16'd300);
    push_query(24'sd0, 24'sd0, 24'sd0);
    push_query(24'sh800000, 24'sh7FFFFF, 24'sh800000);
    push_query(24'sd256, -24'sd256, 24'sd512);
    push_query(24'sd1, 24'sd0, 24'sd0);
    push_load(10'd1023, 24'sd5, 24'sd5, 24'sd5, -16'sd1, 16'd1);

    // accumulator and output saturation, both signs
    set_config(1'b1, 11'd2, 16'd0, 16'd0, 16'hFFFF);
    push_load(10'd0, 24'sd100, 24'sd100, 24'sd100, 16'sh7FFF, 16'd0);
    push_load(10'd1, 24'sd100, 24'sd100, 24'sd100, 16'sh7FFF, 16'd0);
    push_query(24'sd100, 24'sd100, 24'sd100);
    push_load(10'd0, 24'sd100, 24'sd100, 24'sd100, 16'sh8000, 16'd0);
    push_load(10'd1, 24'sd100, 24'sd100, 24'sd100, 16'sh8000, 16'd0);
    push_query(24'sd100, 24'sd100, 24'sd100);

    // nonlocal with clamped factor, then everything zero
    set_config(1'b0, 11'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_load(10'd0, 24'sd0, 24'sd0, 24'sd0, 16'sh7FFF, 16'hFFFF);
    push_load(10'd1, 24'sd4000, 24'sd0, 24'sd0, -16'sd1000, 16'd0);
    push_query(24'sd1, 24'sd1, 24'sd1);
    push_query(24'sh400000, 24'sd0, 24'sd0);
    set_config(1'b0, 11'd2, 16'd0, 16'd0, 16'd0);
    push_query(24'sd1, 24'sd1, 24'sd1);

    // random phases with small counts
    for (int p = 0; p < 11; p++) rand_phase(45, (p == 3) ? 0 : $urandom_range(1, 6));

    wait_drained();
    if (error_cnt == 0 && potential_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/cps_pkg.sv
src/cps_alu.sv
src/cps_datapath.sv
src/cps_ctrl.sv
src/coulomb_potential_sum.sv
test/tb_top.sv
